### rtl/core/gcdc_pkg.sv
// ---------------------------------------------------------------------------
// gcdc_pkg: shared definitions for the gear content-defined chunker
// Command codes, register indexes, field widths and bundle types.
// ---------------------------------------------------------------------------
`default_nettype none

package gcdc_pkg;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int HASH_W   = 64;
   localparam int SIZE_W   = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam int GEAR_DEPTH = 256;
   localparam int GEAR_IDX_W = 8;

   // bytes hashed ahead of the floor length
   localparam logic [SIZE_W-1:0] HASH_WINDOW = 24'd64;

   // defaults for the top level parameters
   localparam int DEF_LEN_BITS    = 24;
   localparam int DEF_OFFSET_BITS = 48;

   // commands
   localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TABLE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_LEN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEIL_LEN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_STRICT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_RELAXED = 3'd4;

   // register reset values
   localparam logic [SIZE_W-1:0] RST_FLOOR_LEN  = 24'd2048;
   localparam logic [SIZE_W-1:0] RST_TARGET_LEN = 24'd8192;
   localparam logic [SIZE_W-1:0] RST_CEIL_LEN   = 24'd65536;

   typedef struct packed {
      logic [SIZE_W-1:0] floor_len;
      logic [SIZE_W-1:0] target_len;
      logic [SIZE_W-1:0] ceil_len;
      logic [HASH_W-1:0] mask_strict;
      logic [HASH_W-1:0] mask_relaxed;
   } cfg_type;

   // beat handed from the table stage to the hash stage
   typedef struct packed {
      logic              finish;
      logic [HASH_W-1:0] gear;
   } stage_type;

endpackage

`default_nettype wire

### rtl/core/gcdc_gear_table.sv
// ---------------------------------------------------------------------------
// gcdc_gear_table: gear value memory and first pipeline stage
// Takes table writes, reads the gear value of each data byte and holds
// data and finish beats for the hash stage.
// ---------------------------------------------------------------------------
`default_nettype none

module gcdc_gear_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [gcdc_pkg::CMD_W-1:0]    command,
   input  wire logic [gcdc_pkg::BYTE_W-1:0]   data_byte,
   input  wire logic [gcdc_pkg::GEAR_IDX_W-1:0] table_index,
   input  wire logic [gcdc_pkg::HASH_W-1:0]   table_word,
   input  wire logic                          advance,
   output      logic                          stage_valid,
   output      gcdc_pkg::stage_type           stage_item
);
   import gcdc_pkg::*;

   logic [HASH_W-1:0] gear_mem [0:GEAR_DEPTH-1];
   logic              valid_ff, valid_in;
   logic              finish_ff;
   logic [HASH_W-1:0] gear_ff;
   logic              pass_on;

   // only data and finish beats reach the hash stage
   assign pass_on = (command == CMD_BYTE) || (command == CMD_FINISH);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (take && pass_on) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && (command == CMD_TABLE)) begin
         gear_mem[table_index] <= table_word;
      end
      if (take) begin
         gear_ff   <= gear_mem[data_byte];
         finish_ff <= (command == CMD_FINISH);
      end
   end

   assign stage_valid       = valid_ff;
   assign stage_item.finish = finish_ff;
   assign stage_item.gear   = gear_ff;

endmodule

`default_nettype wire

### rtl/core/gcdc_hash_core.sv
// ---------------------------------------------------------------------------
// gcdc_hash_core: gear hash, cut decision and result register
// Fingerprint, chunk length, stream offset; one beat per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module gcdc_hash_core #(
   parameter int LEN_BITS    = gcdc_pkg::DEF_LEN_BITS,
   parameter int OFFSET_BITS = gcdc_pkg::DEF_OFFSET_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gcdc_pkg::cfg_type      cfg,
   input  wire logic                   stage_valid,
   input  wire gcdc_pkg::stage_type    stage_item,
   output      logic                   advance,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [OFFSET_BITS-1:0] rsp_chunk_offset,
   output      logic [LEN_BITS-1:0]    rsp_chunk_length
);
   import gcdc_pkg::*;

   localparam int CMP_W = (LEN_BITS > SIZE_W) ? LEN_BITS : SIZE_W;
   localparam int SUM_W = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;

   logic [HASH_W-1:0]      fp_ff, fp_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0] rsp_offset_ff;
   logic [LEN_BITS-1:0]    rsp_length_ff;

   logic [SIZE_W-1:0]   warm;
   logic [LEN_BITS-1:0] len_plus;
   logic [HASH_W-1:0]   fp_hash, mask;
   logic                hashed, tested, cut, emit;
   logic [LEN_BITS-1:0] emit_len;

   assign advance = stage_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      warm     = (cfg.floor_len > HASH_WINDOW) ? (cfg.floor_len - HASH_WINDOW) : '0;
      len_plus = len_ff + LEN_BITS'(1);
      hashed   = CMP_W'(len_ff) >= CMP_W'(warm);
      fp_hash  = {fp_ff[HASH_W-2:0], 1'b0} + stage_item.gear;
      mask     = (CMP_W'(len_plus) < CMP_W'(cfg.target_len)) ? cfg.mask_strict
                                                             : cfg.mask_relaxed;
      tested   = hashed && (CMP_W'(len_plus) >= CMP_W'(cfg.floor_len));
      cut      = (tested && ((fp_hash & mask) == '0))
               || (CMP_W'(len_plus) >= CMP_W'(cfg.ceil_len))
               || (len_plus == '1);

      fp_in     = fp_ff;
      len_in    = len_ff;
      offset_in = offset_ff;
      emit      = 1'b0;
      emit_len  = len_plus;
      if (advance) begin
         if (stage_item.finish) begin
            // flush a partial chunk, then restart the stream
            emit      = (len_ff != '0);
            emit_len  = len_ff;
            fp_in     = '0;
            len_in    = '0;
            offset_in = '0;
         end else if (cut) begin
            emit      = 1'b1;
            fp_in     = '0;
            len_in    = '0;
            offset_in = OFFSET_BITS'(SUM_W'(offset_ff) + SUM_W'(len_plus));
         end else begin
            len_in = len_plus;
            if (hashed) begin
               fp_in = fp_hash;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff        <= '0;
         len_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fp_ff        <= fp_in;
         len_ff       <= len_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_offset_ff <= offset_ff;
         rsp_length_ff <= emit_len;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_offset = rsp_offset_ff;
   assign rsp_chunk_length = rsp_length_ff;

endmodule

`default_nettype wire

### rtl/core/gear_content_defined_chunker_unit.sv
// ---------------------------------------------------------------------------
// gear_content_defined_chunker_unit: gear-hash content-defined chunker
// Cuts a byte stream into chunks with normalized masks; loads its gear
// table through command beats.
// ---------------------------------------------------------------------------
// Usage: one request beat per cycle is taken, sustained, as long as the
// result side keeps up; a beat's result (if any) passes the gear table and
// hash stages into the result register. The rate is set by the hash stage,
// which does the 64-bit shift-add of the gear hash and the mask test, and by
// the gear table, whose single read port serves one data byte per cycle.
// Table-write beats (command 1) only touch the gear memory; entries must be
// written before a data byte reads them, there is no clearing pass. Finish
// (command 2) emits any partial chunk and restarts the offset at zero.
// Configuration writes must go in only while idle; the block does not check.
`default_nettype none

module gear_content_defined_chunker_unit #(
   parameter int LEN_BITS    = gcdc_pkg::DEF_LEN_BITS,
   parameter int OFFSET_BITS = gcdc_pkg::DEF_OFFSET_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [gcdc_pkg::CMD_W-1:0]        req_command,
   input  wire logic [gcdc_pkg::BYTE_W-1:0]       req_data_byte,
   input  wire logic [gcdc_pkg::GEAR_IDX_W-1:0]   req_table_index,
   input  wire logic [gcdc_pkg::HASH_W-1:0]       req_table_word,
   // result channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [OFFSET_BITS-1:0]            rsp_chunk_offset,
   output      logic [LEN_BITS-1:0]               rsp_chunk_length,
   // configuration write port
   input  wire logic                              csr_write_enable,
   input  wire logic [gcdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gcdc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import gcdc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      take;
   logic      advance;
   logic      stage_valid;
   stage_type stage_item;

   // config registers; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FLOOR_LEN:    cfg_in.floor_len    = csr_data[SIZE_W-1:0];
            CSR_TARGET_LEN:   cfg_in.target_len   = csr_data[SIZE_W-1:0];
            CSR_CEIL_LEN:     cfg_in.ceil_len     = csr_data[SIZE_W-1:0];
            CSR_MASK_STRICT:  cfg_in.mask_strict  = csr_data[HASH_W-1:0];
            CSR_MASK_RELAXED: cfg_in.mask_relaxed = csr_data[HASH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.floor_len    <= RST_FLOOR_LEN;
         cfg_ff.target_len   <= RST_TARGET_LEN;
         cfg_ff.ceil_len     <= RST_CEIL_LEN;
         cfg_ff.mask_strict  <= '0;
         cfg_ff.mask_relaxed <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage 1 frees up whenever its beat moves into the hash stage
   assign req_ready = !stage_valid || advance;
   assign take      = req_valid && req_ready;

   gcdc_gear_table u_table (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .command     (req_command),
      .data_byte   (req_data_byte),
      .table_index (req_table_index),
      .table_word  (req_table_word),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   gcdc_hash_core #(
      .LEN_BITS    (LEN_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .stage_valid      (stage_valid),
      .stage_item       (stage_item),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chunk_offset (rsp_chunk_offset),
      .rsp_chunk_length (rsp_chunk_length)
   );

endmodule

`default_nettype wire
